FILE: design/vcs_pkg.sv
// Shared types and constants of the voice command sequencer.
package vcs_pkg;

  typedef enum logic [2:0] {
    PH_RESET = 3'd0,
    PH_IDLE  = 3'd1,
    PH_HOT   = 3'd2,
    PH_LOC   = 3'd3,
    PH_SET   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    REG_HIT_THRESHOLD    = 3'd0,
    REG_WAKE_CLASS       = 3'd1,
    REG_TIMEOUT_LIMIT_MS = 3'd2,
    REG_TICK_PERIOD_US   = 3'd3,
    REG_LOCATION_CLASSES = 3'd4,
    REG_LOCATION_LEDS    = 3'd5,
    REG_VALUE_CLASSES    = 3'd6,
    REG_ON_COLOR         = 3'd7
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int TIMER_W = 16;
  localparam int SCORE_W = 16;
  localparam int CLASS_W = 6;
  localparam int PHASE_W = 3;
  localparam int LED_W   = 3;
  localparam int COLOR_W = 32;
  localparam int ELAPSED_W = 16;
  localparam int PERIOD_W  = 8;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  localparam int ENTRY_STRIDE = 6;
  localparam int LOC_SLOTS    = 5;
  localparam int LOC_IDX_W    = 3;

  // Elapsed microseconds and the exact divide by 1000.
  localparam int PROD_W     = TIMER_W + PERIOD_W;
  localparam int RECIP_W    = 25;
  localparam int DIV_SHIFT  = 34;
  localparam int MS_W       = 15;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd17179870;

  localparam logic [SCORE_W-1:0]   RST_HIT_THRESHOLD = 16'd32768;
  localparam logic [TIMER_W-1:0]   RST_TIMEOUT_MS    = 16'd4000;
  localparam logic [PERIOD_W-1:0]  RST_TICK_PERIOD   = 8'd1;
  localparam logic [14:0]          RST_LOCATION_LEDS = 15'd668;
  localparam logic [COLOR_W-1:0]   RST_ON_COLOR      = 32'hFFFF_FFFF;

endpackage

FILE: design/voice_command_sequencer.sv
// Voice command sequencer: stream of classifier verdicts in, phase and set commands out.
//
//  channel  | direction | beat contents
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | one verdict: timer_now, best_score, best_class
//  m_axis   | out       | one result per verdict: phase, elapsed, set command
//  cfg      | in        | one register write: index and data
//
// Every verdict passes the product, milliseconds and result registers, and one
// verdict is accepted in every cycle while the result side takes beats.
// The depth is set by the tick multiply and the reciprocal multiply for the
// divide by 1000, each followed by a register, before the phase update.
// Reset clears the phase and timing state and loads the register defaults.
// A stalled result beat holds the whole pipeline, and the input stalls with it.
module voice_command_sequencer #(
  parameter int LOCATION_COUNT = 5,
  parameter int CLASS_BITS     = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  // timer_now [15:0], best_score [31:16], best_class [37:32], zeros above.
  input  logic [vcs_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // phase [2:0], led_index [5:3], set_color [37:6], elapsed_ms [53:38], zeros above.
  output logic [vcs_pkg::OUT_DATA_W-1:0]     m_tdata,
  // set_valid [0].
  output logic                               m_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vcs_pkg::*;

  logic [SCORE_W-1:0]   hit_threshold;
  logic [CLASS_W-1:0]   wake_class;
  logic [TIMER_W-1:0]   timeout_limit_ms;
  logic [PERIOD_W-1:0]  tick_period_us;
  logic [29:0]          location_classes;
  logic [14:0]          location_leds;
  logic [11:0]          value_classes;
  logic [COLOR_W-1:0]   on_color;

  logic                 advance;
  logic [TIMER_W-1:0]   prev_timer;
  logic [TIMER_W-1:0]   ticks;

  logic                 v1;
  logic [PROD_W-1:0]    prod1;
  logic [SCORE_W-1:0]   score1;
  logic [CLASS_W-1:0]   cls1;

  logic                 v2;
  logic [MS_W-1:0]      ms2;
  logic [SCORE_W-1:0]   score2;
  logic [CLASS_W-1:0]   cls2;
  logic [PROD_W+RECIP_W-1:0] recip_prod;

  phase_t               phase;
  phase_t               phase_next;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic [LOC_IDX_W-1:0] chosen_location;
  logic [LOC_IDX_W-1:0] chosen_location_next;
  logic                 chosen_value;
  logic                 chosen_value_next;

  logic                 hit;
  logic [ELAPSED_W:0]   acc_sum;
  logic [ELAPSED_W-1:0] acc_sat;
  logic                 wake_match;
  logic                 loc_found;
  logic [LOC_IDX_W-1:0] loc_idx;
  logic                 val0_match;
  logic                 val1_match;

  logic                 set_valid_c;
  logic [LED_W-1:0]     led_c;
  logic [COLOR_W-1:0]   color_c;

  logic                 out_valid;
  logic [PHASE_W-1:0]   out_phase;
  logic                 out_set_valid;
  logic [LED_W-1:0]     out_led;
  logic [COLOR_W-1:0]   out_color;
  logic [ELAPSED_W-1:0] out_elapsed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold    <= RST_HIT_THRESHOLD;
      wake_class       <= '0;
      timeout_limit_ms <= RST_TIMEOUT_MS;
      tick_period_us   <= RST_TICK_PERIOD;
      location_classes <= '0;
      location_leds    <= RST_LOCATION_LEDS;
      value_classes    <= '0;
      on_color         <= RST_ON_COLOR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HIT_THRESHOLD:    hit_threshold    <= cfg_data[SCORE_W-1:0];
        REG_WAKE_CLASS:       wake_class       <= cfg_data[CLASS_W-1:0];
        REG_TIMEOUT_LIMIT_MS: timeout_limit_ms <= cfg_data[TIMER_W-1:0];
        REG_TICK_PERIOD_US:   tick_period_us   <= cfg_data[PERIOD_W-1:0];
        REG_LOCATION_CLASSES: location_classes <= cfg_data[29:0];
        REG_LOCATION_LEDS:    location_leds    <= cfg_data[14:0];
        REG_VALUE_CLASSES:    value_classes    <= cfg_data[11:0];
        REG_ON_COLOR:         on_color         <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || m_tready;
  assign s_tready = advance;
  assign ticks    = s_tdata[TIMER_W-1:0] - prev_timer;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_timer <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
      v2 <= v1;
      if (s_tvalid) begin
        prev_timer <= s_tdata[TIMER_W-1:0];
      end
    end
  end

  assign recip_prod = (PROD_W+RECIP_W)'(prod1) * (PROD_W+RECIP_W)'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (advance) begin
      prod1  <= PROD_W'(tick_period_us) * PROD_W'(ticks);
      score1 <= s_tdata[TIMER_W +: SCORE_W];
      cls1   <= s_tdata[TIMER_W+SCORE_W +: CLASS_W];
      ms2    <= recip_prod[DIV_SHIFT +: MS_W];
      score2 <= score1;
      cls2   <= cls1;
    end
  end

  assign hit        = score2 > hit_threshold;
  assign acc_sum    = {1'b0, elapsed} + (ELAPSED_W+1)'(ms2);
  assign acc_sat    = acc_sum[ELAPSED_W] ? '1 : acc_sum[ELAPSED_W-1:0];
  assign wake_match = cls2[CLASS_BITS-1:0] == wake_class[CLASS_BITS-1:0];
  assign val0_match = value_classes[0 +: CLASS_BITS] == cls2[CLASS_BITS-1:0];
  assign val1_match = value_classes[ENTRY_STRIDE +: CLASS_BITS] == cls2[CLASS_BITS-1:0];

  always_comb begin
    loc_found = 1'b0;
    loc_idx   = '0;
    for (int i = LOCATION_COUNT - 1; i >= 0; i--) begin
      if (location_classes[i*ENTRY_STRIDE +: CLASS_BITS] == cls2[CLASS_BITS-1:0]) begin
        loc_found = 1'b1;
        loc_idx   = LOC_IDX_W'(i);
      end
    end
  end

  always_comb begin
    phase_next           = phase;
    elapsed_next         = elapsed;
    chosen_location_next = chosen_location;
    chosen_value_next    = chosen_value;
    unique case (phase)
      PH_IDLE: begin
        if (hit && wake_match) begin
          elapsed_next = '0;
          phase_next   = PH_HOT;
        end
      end
      PH_HOT: begin
        elapsed_next = acc_sat;
        if (hit) begin
          if (loc_found) begin
            chosen_location_next = loc_idx;
            elapsed_next         = '0;
            phase_next           = PH_LOC;
          end
        end else if (acc_sat > timeout_limit_ms) begin
          phase_next = PH_IDLE;
        end
      end
      PH_LOC: begin
        elapsed_next = acc_sat;
        if (hit) begin
          if (val0_match || val1_match) begin
            chosen_value_next = !val0_match;
            phase_next        = PH_SET;
          end
        end else if (acc_sat > timeout_limit_ms) begin
          phase_next = PH_IDLE;
        end
      end
      PH_SET: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    set_valid_c = (phase == PH_SET);
    led_c       = '0;
    color_c     = '0;
    if (set_valid_c) begin
      for (int j = 0; j < LOC_SLOTS; j++) begin
        if (chosen_location == LOC_IDX_W'(j)) begin
          led_c = location_leds[j*LED_W +: LED_W];
        end
      end
      color_c = chosen_value ? on_color : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      phase           <= PH_RESET;
      elapsed         <= '0;
      chosen_location <= '0;
      chosen_value    <= 1'b0;
    end else if (advance) begin
      out_valid <= v2;
      if (v2) begin
        phase           <= phase_next;
        elapsed         <= elapsed_next;
        chosen_location <= chosen_location_next;
        chosen_value    <= chosen_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v2) begin
      out_phase     <= phase_next;
      out_set_valid <= set_valid_c;
      out_led       <= led_c;
      out_color     <= color_c;
      out_elapsed   <= elapsed_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_set_valid;
  assign m_tdata  = {2'b00, out_elapsed, out_color, out_led, out_phase};

endmodule

FILE: design/vcs_checker.sv
// Port-level checks of the voice command sequencer and their binding.
module vcs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic [vcs_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready
);
  import vcs_pkg::*;

  property p_hold;
    @(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
  endproperty
  a_hold: assert property (p_hold) else $error("result beat changed while stalled");

  property p_ready_when_empty;
    @(posedge clk) disable iff (rst) !m_tvalid |-> s_tready;
  endproperty
  a_ready_when_empty: assert property (p_ready_when_empty)
    else $error("input stalled with an empty result register");

  property p_set_returns_idle;
    @(posedge clk) disable iff (rst)
      m_tvalid && m_tuser |-> m_tdata[PHASE_W-1:0] == PH_IDLE;
  endproperty
  a_set_returns_idle: assert property (p_set_returns_idle)
    else $error("set command without return to idle");

  property p_no_command_zero;
    @(posedge clk) disable iff (rst)
      m_tvalid && !m_tuser |-> m_tdata[PHASE_W +: LED_W + COLOR_W] == '0;
  endproperty
  a_no_command_zero: assert property (p_no_command_zero)
    else $error("led or color set without a command");

endmodule

bind voice_command_sequencer vcs_checker u_vcs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

FILE: verif/voice_command_sequencer_tb.sv
// Self-checking testbench for the voice command sequencer stream block.
`timescale 1ns / 1ps

module voice_command_sequencer_tb;
  import vcs_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 125;

  typedef struct {
    phase_t      phase;
    logic        set_valid;
    logic [2:0]  led;
    logic [31:0] color;
    logic [15:0] elapsed;
  } result_t;

  typedef struct {
    bit          is_cfg;
    cfg_reg_t    reg_sel;
    logic [31:0] value;
    logic [15:0] timer;
    logic [15:0] score;
    logic [5:0]  cls;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Register copies and sequencer state of the prediction.
  logic [15:0] cfg_threshold;
  logic [5:0]  cfg_wake;
  logic [15:0] cfg_timeout;
  logic [7:0]  cfg_tick_us;
  logic [29:0] cfg_loc_classes;
  logic [14:0] cfg_loc_leds;
  logic [11:0] cfg_val_classes;
  logic [31:0] cfg_on_color;

  phase_t      seq_phase;
  logic [15:0] seq_last_timer;
  logic [15:0] seq_elapsed;
  logic [2:0]  seq_loc;
  logic        seq_value;

  result_t     pending_results[$];
  stim_row_t   directed_rows[$];
  result_t     seen_result;
  result_t     no_result;
  int          mismatches;
  int          idle_cycles;
  int          hold_cycles;
  bit          steady;

  voice_command_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  function automatic result_t step_sequencer(input logic [15:0] now, input logic [15:0] score,
                                             input logic [5:0] cls);
    result_t     r;
    logic [15:0] ticks;
    logic [23:0] dt_us;
    logic [15:0] ms;
    logic [16:0] sum;
    logic        hit;
    logic        found;
    int          i;
    ticks = now - seq_last_timer;
    dt_us = 24'(ticks) * 24'(cfg_tick_us);
    ms = 16'(dt_us / 1000);
    hit = score > cfg_threshold;
    seq_last_timer = now;
    r.set_valid = 1'b0;
    r.led = 3'd0;
    r.color = 32'd0;
    found = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (hit && cls == cfg_wake) begin
          seq_elapsed = 16'd0;
          seq_phase = PH_HOT;
        end
      end
      PH_HOT: begin
        sum = {1'b0, seq_elapsed} + {1'b0, ms};
        seq_elapsed = sum[16] ? 16'hFFFF : sum[15:0];
        if (hit) begin
          for (i = 0; i < LOC_SLOTS; i++) begin
            if (!found && cfg_loc_classes[6*i +: 6] == cls) begin
              found = 1'b1;
              seq_loc = 3'(i);
              seq_elapsed = 16'd0;
              seq_phase = PH_LOC;
            end
          end
        end else if (seq_elapsed > cfg_timeout) begin
          seq_phase = PH_IDLE;
        end
      end
      PH_LOC: begin
        sum = {1'b0, seq_elapsed} + {1'b0, ms};
        seq_elapsed = sum[16] ? 16'hFFFF : sum[15:0];
        if (hit) begin
          for (i = 0; i < 2; i++) begin
            if (!found && cfg_val_classes[6*i +: 6] == cls) begin
              found = 1'b1;
              seq_value = i[0];
              seq_phase = PH_SET;
            end
          end
        end else if (seq_elapsed > cfg_timeout) begin
          seq_phase = PH_IDLE;
        end
      end
      PH_SET: begin
        r.set_valid = 1'b1;
        r.led = cfg_loc_leds[3*seq_loc +: 3];
        r.color = seq_value ? cfg_on_color : 32'd0;
        seq_phase = PH_IDLE;
      end
      default: seq_phase = PH_IDLE;
    endcase
    r.phase = seq_phase;
    r.elapsed = seq_elapsed;
    return r;
  endfunction

  function automatic void add_write(input cfg_reg_t idx, input logic [31:0] value);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.reg_sel = idx;
    row.value = value;
    row.typed = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_verdict(input logic [15:0] t, input logic [15:0] sc,
                                      input logic [5:0] c);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.timer = t;
    row.score = sc;
    row.cls = c;
    row.typed = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_known(input logic [15:0] t, input logic [15:0] sc,
                                    input logic [5:0] c, input phase_t ph,
                                    input logic [15:0] el);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.timer = t;
    row.score = sc;
    row.cls = c;
    row.typed = 1'b1;
    row.want = '{ph, 1'b0, 3'd0, 32'd0, el};
    directed_rows.push_back(row);
  endfunction

  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
    settle();
    @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HIT_THRESHOLD:    cfg_threshold = value[15:0];
      REG_WAKE_CLASS:       cfg_wake = value[5:0];
      REG_TIMEOUT_LIMIT_MS: cfg_timeout = value[15:0];
      REG_TICK_PERIOD_US:   cfg_tick_us = value[7:0];
      REG_LOCATION_CLASSES: cfg_loc_classes = value[29:0];
      REG_LOCATION_LEDS:    cfg_loc_leds = value[14:0];
      REG_VALUE_CLASSES:    cfg_val_classes = value[11:0];
      default:              cfg_on_color = value;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_verdict(input logic [15:0] t, input logic [15:0] sc, input logic [5:0] c,
                              input bit typed, input result_t want);
    int      gap;
    result_t due;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {2'b00, c, sc, t};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    due = step_sequencer(t, sc, c);
    pending_results.push_back(typed ? want : due);
  endtask

  task automatic shuffle_settings(input bit all);
    if (all || $urandom_range(0, 2) == 0)
      write_register(REG_HIT_THRESHOLD, pick_value(32'd0, 32'hFFFF,
                     $urandom_range(16'h4000, 16'hC000), $urandom & 32'hFFFF));
    if (all || $urandom_range(0, 2) == 0)
      write_register(REG_WAKE_CLASS, $urandom_range(0, 63));
    if (all || $urandom_range(0, 2) == 0)
      write_register(REG_TIMEOUT_LIMIT_MS, pick_value(32'd0, 32'hFFFF,
                     $urandom_range(0, 5000), $urandom_range(0, 200)));
    if (all || $urandom_range(0, 2) == 0)
      write_register(REG_TICK_PERIOD_US, pick_value(32'd0, 32'd1, 32'd255,
                     $urandom_range(1, 255)));
    if (all || $urandom_range(0, 2) == 0)
      write_register(REG_LOCATION_CLASSES, $urandom & 32'h3FFF_FFFF);
    if (all || $urandom_range(0, 2) == 0)
      write_register(REG_LOCATION_LEDS, $urandom & 32'h7FFF);
    if (all || $urandom_range(0, 2) == 0)
      write_register(REG_VALUE_CLASSES, pick_value($urandom & 32'hFFF, $urandom & 32'hFFF,
                     $urandom & 32'hFFF, 32'h0));
    if (all || $urandom_range(0, 2) == 0)
      write_register(REG_ON_COLOR, pick_value(32'd0, 32'hFFFF_FFFF, $urandom, $urandom));
  endtask

  task automatic make_verdict(output logic [15:0] t, output logic [15:0] sc,
                              output logic [5:0] c);
    logic [15:0] delta;
    int          slot;
    case ($urandom_range(0, 9))
      0:       delta = 16'd0;
      1, 2:    delta = 16'($urandom);
      default: delta = 16'($urandom_range(0, 3000));
    endcase
    t = seq_last_timer + delta;
    if ($urandom_range(0, 99) < 75) begin
      if (cfg_threshold == 16'hFFFF) sc = 16'hFFFF;
      else sc = 16'($urandom_range(int'(cfg_threshold) + 1, 65535));
      case (seq_phase)
        PH_IDLE: c = cfg_wake;
        PH_HOT: begin
          slot = $urandom_range(0, LOC_SLOTS - 1);
          c = cfg_loc_classes[6*slot +: 6];
        end
        PH_LOC: begin
          slot = $urandom_range(0, 1);
          c = cfg_val_classes[6*slot +: 6];
        end
        default: c = 6'($urandom);
      endcase
    end else begin
      sc = 16'($urandom);
      c = 6'($urandom);
    end
  endtask

  // Each result beat is checked against the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result.phase = phase_t'(m_tdata[2:0]);
      seen_result.set_valid = m_tuser;
      seen_result.led = m_tdata[5:3];
      seen_result.color = m_tdata[37:6];
      seen_result.elapsed = m_tdata[53:38];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing pending: phase %0d set %0b led %0d",
                   seen_result.phase, seen_result.set_valid, seen_result.led,
                   " color %h ms %0d", seen_result.color, seen_result.elapsed);
      end else begin
        if (seen_result.phase !== pending_results[0].phase ||
            seen_result.set_valid !== pending_results[0].set_valid ||
            seen_result.led !== pending_results[0].led ||
            seen_result.color !== pending_results[0].color ||
            seen_result.elapsed !== pending_results[0].elapsed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch (exp/got): phase %0d/%0d set %0b/%0b led %0d/%0d",
                     pending_results[0].phase, seen_result.phase,
                     pending_results[0].set_valid, seen_result.set_valid,
                     pending_results[0].led, seen_result.led,
                     " color %h/%h ms %0d/%0d",
                     pending_results[0].color, seen_result.color,
                     pending_results[0].elapsed, seen_result.elapsed);
        end
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    m_tready = 1'b0;
    hold_cycles = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        hold_cycles--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) hold_cycles = pick_gap();
      end
    end
  end

  initial begin
    idle_cycles = 0;
    wait (rst === 1'b0);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : main_flow
    int          k;
    int          phase_no;
    logic [15:0] t;
    logic [15:0] sc;
    logic [5:0]  c;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_HIT_THRESHOLD;
    cfg_data = '0;
    steady = 1'b0;
    mismatches = 0;
    no_result = '{PH_RESET, 1'b0, 3'd0, 32'd0, 16'd0};
    cfg_threshold = RST_HIT_THRESHOLD;
    cfg_wake = 6'd0;
    cfg_timeout = RST_TIMEOUT_MS;
    cfg_tick_us = RST_TICK_PERIOD;
    cfg_loc_classes = 30'd0;
    cfg_loc_leds = RST_LOCATION_LEDS;
    cfg_val_classes = 12'd0;
    cfg_on_color = RST_ON_COLOR;
    seq_phase = PH_RESET;
    seq_last_timer = 16'd0;
    seq_elapsed = 16'd0;
    seq_loc = 3'd0;
    seq_value = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Register defaults: first item, equal timers, score at the threshold,
    // an unlisted hit, a timer wrap and a set command with the black value.
    add_known(16'h1234, 16'h0000, 6'd0, PH_IDLE, 16'd0);
    add_known(16'h1234, 16'hFFFF, 6'd0, PH_HOT, 16'd0);
    add_known(16'h1234, 16'h8000, 6'd5, PH_HOT, 16'd0);
    add_verdict(16'h1BF8, 16'hFFFF, 6'd63);
    add_known(16'h1BF8, 16'h8001, 6'd0, PH_LOC, 16'd0);
    add_verdict(16'h0010, 16'h0000, 6'd0);
    add_verdict(16'h0010, 16'hFFFF, 6'd0);
    add_verdict(16'h0020, 16'h0000, 6'd0);
    // Zero threshold and timeout, slowest tick, duplicated list entries.
    add_write(REG_HIT_THRESHOLD, 32'd0);
    add_write(REG_WAKE_CLASS, 32'd63);
    add_write(REG_TIMEOUT_LIMIT_MS, 32'd0);
    add_write(REG_TICK_PERIOD_US, 32'd255);
    add_write(REG_LOCATION_CLASSES, {2'b00, 6'd62, 6'd0, 6'd63, 6'd63, 6'd10});
    add_write(REG_LOCATION_LEDS, 32'h7FFF);
    add_write(REG_VALUE_CLASSES, {20'd0, 6'd63, 6'd1});
    add_write(REG_ON_COLOR, 32'hA5C3_0F81);
    add_known(16'h0000, 16'h0001, 6'd63, PH_HOT, 16'd0);
    add_verdict(16'hFFFF, 16'h0000, 6'd63);
    add_known(16'hFFFF, 16'h0001, 6'd63, PH_HOT, 16'd0);
    add_known(16'hFFFF, 16'h0000, 6'd0, PH_HOT, 16'd0);
    add_verdict(16'hFFFF, 16'hFFFF, 6'd63);
    add_verdict(16'h7FFF, 16'h0005, 6'd0);
    add_verdict(16'h7FFF, 16'h0005, 6'd63);
    add_verdict(16'h7FFF, 16'h0000, 6'd0);
    // Widest timeout: the elapsed total saturates, then a zero tick freezes it.
    add_write(REG_TIMEOUT_LIMIT_MS, 32'hFFFF);
    add_write(REG_HIT_THRESHOLD, 32'hFFFE);
    add_known(16'h0000, 16'hFFFF, 6'd63, PH_HOT, 16'd0);
    add_verdict(16'hFFFF, 16'h0000, 6'd0);
    add_verdict(16'hFFFE, 16'h0000, 6'd0);
    add_verdict(16'hFFFD, 16'h0000, 6'd0);
    add_known(16'hFFFC, 16'h0000, 6'd0, PH_HOT, 16'hFFFF);
    add_write(REG_TICK_PERIOD_US, 32'd0);
    add_known(16'h1234, 16'h0000, 6'd0, PH_HOT, 16'hFFFF);
    add_verdict(16'h1234, 16'hFFFF, 6'd0);

    for (k = 0; k < directed_rows.size(); k++) begin
      if (directed_rows[k].is_cfg)
        write_register(directed_rows[k].reg_sel, directed_rows[k].value);
      else
        send_verdict(directed_rows[k].timer, directed_rows[k].score, directed_rows[k].cls,
                     directed_rows[k].typed, directed_rows[k].want);
    end

    for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
      steady = (phase_no == 2 || phase_no == 5);
      shuffle_settings(phase_no == 0);
      repeat (ITEMS_PER_PHASE) begin
        make_verdict(t, sc, c);
        send_verdict(t, sc, c, 1'b0, no_result);
      end
    end

    steady = 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
